/* hdl/tpd_pkg.sv */
// ----------------------------------------------------------------------------
// tpd_pkg
// Shared constants for the pitch-to-duty block: field widths, register
// indexes and reset values, and the sizes of the serial arithmetic units.
// ----------------------------------------------------------------------------
`default_nettype none

package tpd_pkg;

    localparam int FRAC_BITS_DEFAULT = 8;
    localparam int COUNT_W = 15;
    localparam int FREQ_OUT_W = 23;
    localparam int DUTY_W = 8;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int WEIGHT_W = 9;
    localparam int WEIGHT_FULL = 256;
    localparam int WEIGHT_SHIFT = 8;

    localparam int GATE_W = 16;
    localparam int RUN_W = 8;
    localparam int MAP_W = 15;

    localparam int QUO_W = 8;
    localparam int NUM_W = MAP_W + QUO_W;

    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA_FREQ = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA_DELTA = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_STABLE_EPSILON = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_STABLE_TARGET = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_AUTO_BASE_ENABLE = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_DELTA_GATE = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_MAP_LOW = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_MAP_HIGH = 3'd7;

    localparam logic [WEIGHT_W-1:0] ALPHA_FREQ_RESET = 9'd128;
    localparam logic [WEIGHT_W-1:0] ALPHA_DELTA_RESET = 9'd154;
    localparam logic [GATE_W-1:0] STABLE_EPSILON_RESET = 16'd512;
    localparam logic [RUN_W-1:0] STABLE_TARGET_RESET = 8'd20;
    localparam logic AUTO_BASE_ENABLE_RESET = 1'b1;
    localparam logic [GATE_W-1:0] DELTA_GATE_RESET = 16'd1024;
    localparam logic [MAP_W-1:0] MAP_LOW_RESET = 15'd4;
    localparam logic [MAP_W-1:0] MAP_HIGH_RESET = 15'd20;

    localparam logic [RUN_W-1:0] RUN_MAX = 8'd255;
    localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;

endpackage

`default_nettype wire

/* hdl/tpd_smooth.sv */
// ----------------------------------------------------------------------------
// tpd_smooth
// Bit-serial exponential filter: y' = y + floor(w * (x - y) / 256), with the
// weight consumed one bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
`default_nettype none

module tpd_smooth #(
    parameter int VAL_W = tpd_pkg::COUNT_W + tpd_pkg::FRAC_BITS_DEFAULT
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            start,
    input  wire [tpd_pkg::WEIGHT_W-1:0]    weight,
    input  wire [VAL_W-1:0]                x,
    input  wire [VAL_W-1:0]                y,
    output logic                           done,
    output logic [VAL_W-1:0]               result
);

    localparam int WW = tpd_pkg::WEIGHT_W;
    localparam int AW = VAL_W + WW + 1;
    localparam int CNT_W = $clog2(WW);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WW - 1);
    localparam logic [WW-1:0] W_FULL = WW'(tpd_pkg::WEIGHT_FULL);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [WW-1:0]           w_reg, w_next;
    logic signed [VAL_W:0]   d_reg, d_next;
    logic [VAL_W-1:0]        y_reg, y_next;
    logic signed [AW-1:0]    acc_reg, acc_next;

    logic [WW-1:0]           w_sat;
    logic signed [AW-1:0]    d_ext;
    logic signed [VAL_W+1:0] acc_scaled;
    logic signed [VAL_W+1:0] sum;

    // Weights above full scale act as full scale.
    assign w_sat = (weight > W_FULL) ? W_FULL : weight;
    assign d_ext = {{(AW-VAL_W-1){d_reg[VAL_W]}}, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        w_next    = w_reg;
        d_next    = d_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            w_next    = w_sat;
            d_next    = $signed({1'b0, x}) - $signed({1'b0, y});
            y_next    = y;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next = (acc_reg <<< 1) + (w_reg[WW-1] ? d_ext : '0);
            w_next   = {w_reg[WW-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg   <= w_next;
        d_reg   <= d_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
    end

    assign acc_scaled = acc_reg[AW-1:tpd_pkg::WEIGHT_SHIFT];
    assign sum        = $signed({2'b00, y_reg}) + acc_scaled;
    assign result     = sum[VAL_W-1:0];
    assign done       = done_reg;

endmodule

`default_nettype wire

/* hdl/tpd_div.sv */
// ----------------------------------------------------------------------------
// tpd_div
// Restoring divider that yields one quotient bit per cycle. The caller
// guarantees that the quotient fits in QUO_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tpd_div (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire [tpd_pkg::NUM_W-1:0]     num,
    input  wire [tpd_pkg::MAP_W-1:0]     den,
    output logic                         done,
    output logic [tpd_pkg::QUO_W-1:0]    quotient
);

    localparam int NW = tpd_pkg::NUM_W;
    localparam int QW = tpd_pkg::QUO_W;
    localparam int CNT_W = $clog2(QW);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QW - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [NW-1:0]     rem_reg, rem_next;
    logic [NW-1:0]     dsh_reg, dsh_next;
    logic [QW-1:0]     q_reg, q_next;
    logic              fits;

    assign fits = (rem_reg >= dsh_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = num;
            dsh_next  = {{(NW-tpd_pkg::MAP_W){1'b0}}, den} << (QW - 1);
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (rem_reg - dsh_reg) : rem_reg;
            q_next   = {q_reg[QW-2:0], fits};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

/* hdl/theremin_pitch_to_duty.sv */
// ----------------------------------------------------------------------------
// theremin_pitch_to_duty
// Smooths a pulse count, tracks stability, maintains a baseline and maps the
// smoothed baseline difference onto an 8-bit duty value.
//
//   Channel   Handshake               Payload
//   input     in_valid / in_ready     pulse_count, capture_base
//   output    out_valid / out_ready   duty, is_stable, filtered_freq,
//                                     baseline_freq
//   config    cfg_we                  cfg_addr, cfg_wdata
//
// Each item makes two passes through the 9-step serial filter multiplier and,
// unless the map bounds settle the duty, one pass through the 8-step divider.
// Items are processed one at a time; in_ready is high only while idle.
// The finished result sits in an output register, so the next item may be
// taken while it waits; a stalled output holds the block before its load.
// Reset clears all filter state and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module theremin_pitch_to_duty #(
    parameter int FRAC_BITS = tpd_pkg::FRAC_BITS_DEFAULT
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    output logic                              in_ready,
    input  wire [tpd_pkg::COUNT_W-1:0]        pulse_count,
    input  wire                               capture_base,
    output logic                              out_valid,
    input  wire                               out_ready,
    output logic [tpd_pkg::DUTY_W-1:0]        duty,
    output logic                              is_stable,
    output logic [tpd_pkg::FREQ_OUT_W-1:0]    filtered_freq,
    output logic [tpd_pkg::FREQ_OUT_W-1:0]    baseline_freq,
    input  wire                               cfg_we,
    input  wire [tpd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire [tpd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int VAL_W = tpd_pkg::COUNT_W + FRAC_BITS;
    localparam int OW = tpd_pkg::FREQ_OUT_W;
    localparam int MW = tpd_pkg::MAP_W;
    localparam int NW = tpd_pkg::NUM_W;
    localparam int QW = tpd_pkg::QUO_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FREQ  = 4'd1;
    localparam logic [3:0] S_STAB  = 4'd2;
    localparam logic [3:0] S_DIFF  = 4'd3;
    localparam logic [3:0] S_DELTA = 4'd4;
    localparam logic [3:0] S_MAP   = 4'd5;
    localparam logic [3:0] S_SCALE = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [tpd_pkg::WEIGHT_W-1:0] alpha_freq_reg, alpha_delta_reg;
    logic [tpd_pkg::GATE_W-1:0]   stable_epsilon_reg, delta_gate_reg;
    logic [tpd_pkg::RUN_W-1:0]    stable_target_reg;
    logic                         auto_base_enable_reg;
    logic [MW-1:0]                map_low_reg, map_high_reg;

    logic [3:0]                   state_reg, state_next;
    logic [VAL_W-1:0]             freq_filter_reg, freq_filter_next;
    logic [VAL_W-1:0]             previous_freq_reg, previous_freq_next;
    logic [VAL_W-1:0]             baseline_reg, baseline_next;
    logic [VAL_W-1:0]             delta_filter_reg, delta_filter_next;
    logic [tpd_pkg::RUN_W-1:0]    stable_run_reg, stable_run_next;
    logic                         capture_reg, capture_next;
    logic                         stable_reg, stable_next;
    logic [MW-1:0]                span_reg, span_next;
    logic [MW-1:0]                den_reg, den_next;
    logic [tpd_pkg::DUTY_W-1:0]   duty_reg, duty_next;
    logic                         out_valid_reg, out_valid_next;
    logic [tpd_pkg::DUTY_W-1:0]   out_duty_reg, out_duty_next;
    logic                         out_stable_reg, out_stable_next;
    logic [OW-1:0]                out_freq_reg, out_freq_next;
    logic [OW-1:0]                out_base_reg, out_base_next;

    logic                         accept;
    logic                         smooth_start, smooth_done;
    logic [tpd_pkg::WEIGHT_W-1:0] smooth_w;
    logic [VAL_W-1:0]             smooth_x, smooth_y, smooth_result;
    logic                         div_start, div_done;
    logic [QW-1:0]                div_quotient;

    logic [VAL_W-1:0]             sample;
    logic [VAL_W-1:0]             change;
    logic [VAL_W-1:0]             diff;
    logic                         gate_hit, small_change, run_stable;
    logic [tpd_pkg::RUN_W-1:0]    run_inc;
    logic [MW-1:0]                level;
    logic [NW-1:0]                scaled, limit;
    logic [VAL_W+OW-1:0]          freq_wide, base_wide;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign sample   = {pulse_count, {FRAC_BITS{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_freq_reg       <= tpd_pkg::ALPHA_FREQ_RESET;
            alpha_delta_reg      <= tpd_pkg::ALPHA_DELTA_RESET;
            stable_epsilon_reg   <= tpd_pkg::STABLE_EPSILON_RESET;
            stable_target_reg    <= tpd_pkg::STABLE_TARGET_RESET;
            auto_base_enable_reg <= tpd_pkg::AUTO_BASE_ENABLE_RESET;
            delta_gate_reg       <= tpd_pkg::DELTA_GATE_RESET;
            map_low_reg          <= tpd_pkg::MAP_LOW_RESET;
            map_high_reg         <= tpd_pkg::MAP_HIGH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                tpd_pkg::REG_ALPHA_FREQ:
                    alpha_freq_reg <= cfg_wdata[tpd_pkg::WEIGHT_W-1:0];
                tpd_pkg::REG_ALPHA_DELTA:
                    alpha_delta_reg <= cfg_wdata[tpd_pkg::WEIGHT_W-1:0];
                tpd_pkg::REG_STABLE_EPSILON:
                    stable_epsilon_reg <= cfg_wdata[tpd_pkg::GATE_W-1:0];
                tpd_pkg::REG_STABLE_TARGET:
                    stable_target_reg <= cfg_wdata[tpd_pkg::RUN_W-1:0];
                tpd_pkg::REG_AUTO_BASE_ENABLE:
                    auto_base_enable_reg <= cfg_wdata[0];
                tpd_pkg::REG_DELTA_GATE:
                    delta_gate_reg <= cfg_wdata[tpd_pkg::GATE_W-1:0];
                tpd_pkg::REG_MAP_LOW:
                    map_low_reg <= cfg_wdata[MW-1:0];
                tpd_pkg::REG_MAP_HIGH:
                    map_high_reg <= cfg_wdata[MW-1:0];
                default:
                    ;
            endcase
        end
    end

    // The filter unit serves the frequency pass on transfer and the delta pass later.
    assign smooth_start = accept || (state_reg == S_DIFF);
    assign smooth_w     = accept ? alpha_freq_reg : alpha_delta_reg;
    assign smooth_x     = accept ? sample : diff;
    assign smooth_y     = accept ? freq_filter_reg : delta_filter_reg;

    tpd_smooth #(
        .VAL_W (VAL_W)
    ) u_smooth (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (smooth_start),
        .weight (smooth_w),
        .x      (smooth_x),
        .y      (smooth_y),
        .done   (smooth_done),
        .result (smooth_result)
    );

    tpd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (scaled),
        .den      (den_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign change = (freq_filter_reg >= previous_freq_reg)
                    ? (freq_filter_reg - previous_freq_reg)
                    : (previous_freq_reg - freq_filter_reg);
    assign gate_hit     = (delta_filter_reg >= VAL_W'(delta_gate_reg));
    assign small_change = (change < VAL_W'(stable_epsilon_reg));
    assign run_inc      = (stable_run_reg == tpd_pkg::RUN_MAX)
                          ? stable_run_reg : (stable_run_reg + 1'b1);
    assign run_stable   = !gate_hit && small_change && (run_inc >= stable_target_reg);

    assign diff  = (baseline_reg > freq_filter_reg) ? (baseline_reg - freq_filter_reg) : '0;
    assign level = delta_filter_reg[VAL_W-1:FRAC_BITS];

    // The span times 255, compared with the span of the map range times 256.
    assign scaled    = {span_reg, {QW{1'b0}}} - {{QW{1'b0}}, span_reg};
    assign limit     = {den_reg, {QW{1'b0}}};
    assign div_start = (state_reg == S_SCALE) && (scaled < limit);

    assign freq_wide = {{OW{1'b0}}, freq_filter_reg};
    assign base_wide = {{OW{1'b0}}, baseline_reg};

    always_comb
    begin
        state_next         = state_reg;
        freq_filter_next   = freq_filter_reg;
        previous_freq_next = previous_freq_reg;
        baseline_next      = baseline_reg;
        delta_filter_next  = delta_filter_reg;
        stable_run_next    = stable_run_reg;
        capture_next       = capture_reg;
        stable_next        = stable_reg;
        span_next          = span_reg;
        den_next           = den_reg;
        duty_next          = duty_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        out_duty_next      = out_duty_reg;
        out_stable_next    = out_stable_reg;
        out_freq_next      = out_freq_reg;
        out_base_next      = out_base_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    capture_next = capture_base;
                    state_next   = S_FREQ;
                end
            end
            S_FREQ:
            begin
                if (smooth_done)
                begin
                    freq_filter_next = smooth_result;
                    state_next       = S_STAB;
                end
            end
            S_STAB:
            begin
                if (!gate_hit && small_change)
                begin
                    stable_run_next = run_inc;
                end
                else
                begin
                    stable_run_next = '0;
                end
                stable_next        = run_stable;
                previous_freq_next = freq_filter_reg;
                if (capture_reg)
                begin
                    baseline_next   = freq_filter_reg;
                    stable_run_next = '0;
                end
                if (run_stable && auto_base_enable_reg)
                begin
                    baseline_next = freq_filter_reg;
                end
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                state_next = S_DELTA;
            end
            S_DELTA:
            begin
                if (smooth_done)
                begin
                    delta_filter_next = smooth_result;
                    state_next        = S_MAP;
                end
            end
            S_MAP:
            begin
                span_next = level - map_low_reg;
                den_next  = map_high_reg - map_low_reg;
                if ((map_high_reg <= map_low_reg) || (level <= map_low_reg))
                begin
                    duty_next  = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                if (div_start)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    duty_next  = tpd_pkg::DUTY_MAX;
                    state_next = S_OUT;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    duty_next  = div_quotient;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_duty_next   = duty_reg;
                    out_stable_next = stable_reg;
                    out_freq_next   = freq_wide[OW-1:0];
                    out_base_next   = base_wide[OW-1:0];
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            freq_filter_reg   <= '0;
            previous_freq_reg <= '0;
            baseline_reg      <= '0;
            delta_filter_reg  <= '0;
            stable_run_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            freq_filter_reg   <= freq_filter_next;
            previous_freq_reg <= previous_freq_next;
            baseline_reg      <= baseline_next;
            delta_filter_reg  <= delta_filter_next;
            stable_run_reg    <= stable_run_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        capture_reg    <= capture_next;
        stable_reg     <= stable_next;
        span_reg       <= span_next;
        den_reg        <= den_next;
        duty_reg       <= duty_next;
        out_duty_reg   <= out_duty_next;
        out_stable_reg <= out_stable_next;
        out_freq_reg   <= out_freq_next;
        out_base_reg   <= out_base_next;
    end

    assign out_valid     = out_valid_reg;
    assign duty          = out_duty_reg;
    assign is_stable     = out_stable_reg;
    assign filtered_freq = out_freq_reg;
    assign baseline_freq = out_base_reg;

endmodule

`default_nettype wire

/* tb/sv/theremin_pitch_to_duty_tb.sv */
// ----------------------------------------------------------------------------
// theremin_pitch_to_duty_tb
// Self-checking testbench for the pitch-to-duty block. A predictor in the
// bench keeps its own copy of the filter state and of the register settings
// and works out the result of every accepted pulse count. A checker compares
// each result transfer field by field with the oldest prediction. Directed
// items cover the field extremes and the corner cases; random hand gestures
// under several register settings, random idling on both channels and a long
// receiver hold-off cover the rest.
// ----------------------------------------------------------------------------

module theremin_pitch_to_duty_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VAL_W = tpd_pkg::COUNT_W + tpd_pkg::FRAC_BITS_DEFAULT;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PRINT_LIMIT = 100;

    typedef struct packed {
        logic [tpd_pkg::DUTY_W-1:0]     duty;
        logic                           stable;
        logic [tpd_pkg::FREQ_OUT_W-1:0] freq;
        logic [tpd_pkg::FREQ_OUT_W-1:0] base;
    } pitch_result_t;

    typedef struct {
        logic [tpd_pkg::WEIGHT_W-1:0] alpha_freq;
        logic [tpd_pkg::WEIGHT_W-1:0] alpha_delta;
        logic [tpd_pkg::GATE_W-1:0]   epsilon;
        logic [tpd_pkg::RUN_W-1:0]    target;
        logic                         auto_base;
        logic [tpd_pkg::GATE_W-1:0]   gate;
        logic [tpd_pkg::MAP_W-1:0]    map_low;
        logic [tpd_pkg::MAP_W-1:0]    map_high;
    } tuning_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [tpd_pkg::COUNT_W-1:0]    pulse_count = '0;
    logic                           capture_base = 1'b0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [tpd_pkg::DUTY_W-1:0]     duty;
    logic                           is_stable;
    logic [tpd_pkg::FREQ_OUT_W-1:0] filtered_freq;
    logic [tpd_pkg::FREQ_OUT_W-1:0] baseline_freq;
    logic                           cfg_we = 1'b0;
    logic [tpd_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [tpd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    tuning_t                    tuning;
    logic [VAL_W-1:0]           freq_avg = '0;
    logic [VAL_W-1:0]           freq_prev = '0;
    logic [VAL_W-1:0]           base_freq = '0;
    logic [VAL_W-1:0]           delta_avg = '0;
    logic [tpd_pkg::RUN_W-1:0]  run_len = '0;

    pitch_result_t pitch_results_due[$];
    int            mismatch_count = 0;
    int            quiet_cycles = 0;
    int            in_idle_pct = 17;
    int            out_idle_pct = 17;
    int            stall_request = 0;
    int            stall_left = 0;

    theremin_pitch_to_duty dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pulse_count  (pulse_count),
        .capture_base (capture_base),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .duty         (duty),
        .is_stable    (is_stable),
        .filtered_freq(filtered_freq),
        .baseline_freq(baseline_freq),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    always #2 clk = ~clk;

    function automatic logic [VAL_W-1:0] smooth_toward(
        input logic [tpd_pkg::WEIGHT_W-1:0] weight,
        input logic [VAL_W-1:0] sample,
        input logic [VAL_W-1:0] held);
        longint unsigned w;
        longint unsigned acc;
        w = (weight > tpd_pkg::WEIGHT_FULL) ? tpd_pkg::WEIGHT_FULL : weight;
        acc = w * sample + (tpd_pkg::WEIGHT_FULL - w) * held;
        return acc[tpd_pkg::WEIGHT_SHIFT +: VAL_W];
    endfunction

    function automatic pitch_result_t predict_window(
        input logic [tpd_pkg::COUNT_W-1:0] count,
        input logic capture);
        logic [VAL_W-1:0]          sample;
        logic [VAL_W-1:0]          change;
        logic [VAL_W-1:0]          gap_to_base;
        logic [tpd_pkg::MAP_W-1:0] level;
        longint unsigned           span;
        longint unsigned           above_low;
        longint unsigned           scaled;
        logic                      steady;
        pitch_result_t             r;
        sample = {count, {tpd_pkg::FRAC_BITS_DEFAULT{1'b0}}};
        freq_avg = smooth_toward(tuning.alpha_freq, sample, freq_avg);
        change = (freq_avg >= freq_prev) ? freq_avg - freq_prev : freq_prev - freq_avg;
        steady = 1'b0;
        if (delta_avg >= tuning.gate)
        begin
            run_len = '0;
        end
        else if (change < tuning.epsilon)
        begin
            if (run_len < tpd_pkg::RUN_MAX)
            begin
                run_len = run_len + 1'b1;
            end
            steady = (run_len >= tuning.target);
        end
        else
        begin
            run_len = '0;
        end
        freq_prev = freq_avg;
        if (capture)
        begin
            base_freq = freq_avg;
            run_len = '0;
        end
        if (steady && tuning.auto_base)
        begin
            base_freq = freq_avg;
        end
        gap_to_base = (base_freq > freq_avg) ? base_freq - freq_avg : '0;
        delta_avg = smooth_toward(tuning.alpha_delta, gap_to_base, delta_avg);
        level = delta_avg[VAL_W-1 -: tpd_pkg::MAP_W];
        if (tuning.map_high <= tuning.map_low || level <= tuning.map_low)
        begin
            r.duty = '0;
        end
        else
        begin
            span = tuning.map_high - tuning.map_low;
            above_low = level - tuning.map_low;
            scaled = (above_low * 255) / span;
            r.duty = (scaled > tpd_pkg::DUTY_MAX) ? tpd_pkg::DUTY_MAX
                                                  : tpd_pkg::DUTY_W'(scaled);
        end
        r.stable = steady;
        r.freq = freq_avg;
        r.base = base_freq;
        return r;
    endfunction

    function automatic tuning_t reset_tuning();
        tuning_t t;
        t.alpha_freq = tpd_pkg::ALPHA_FREQ_RESET;
        t.alpha_delta = tpd_pkg::ALPHA_DELTA_RESET;
        t.epsilon = tpd_pkg::STABLE_EPSILON_RESET;
        t.target = tpd_pkg::STABLE_TARGET_RESET;
        t.auto_base = tpd_pkg::AUTO_BASE_ENABLE_RESET;
        t.gate = tpd_pkg::DELTA_GATE_RESET;
        t.map_low = tpd_pkg::MAP_LOW_RESET;
        t.map_high = tpd_pkg::MAP_HIGH_RESET;
        return t;
    endfunction

    function automatic logic [tpd_pkg::WEIGHT_W-1:0] random_weight();
        case ($urandom_range(9))
            0: return '0;
            1: return tpd_pkg::WEIGHT_W'(tpd_pkg::WEIGHT_FULL);
            2: return tpd_pkg::WEIGHT_W'($urandom_range(tpd_pkg::WEIGHT_FULL + 1, 511));
            default: return tpd_pkg::WEIGHT_W'($urandom_range(16, tpd_pkg::WEIGHT_FULL));
        endcase
    endfunction

    function automatic logic [tpd_pkg::GATE_W-1:0] random_threshold(input int lo,
                                                                    input int hi);
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return tpd_pkg::GATE_W'($urandom_range(lo, hi));
        endcase
    endfunction

    function automatic tuning_t random_tuning();
        tuning_t t;
        int      top;
        t.alpha_freq = random_weight();
        t.alpha_delta = random_weight();
        t.epsilon = random_threshold(64, 4096);
        t.gate = random_threshold(256, 16384);
        case ($urandom_range(9))
            0: t.target = '0;
            1: t.target = tpd_pkg::RUN_MAX;
            default: t.target = tpd_pkg::RUN_W'($urandom_range(1, 40));
        endcase
        t.auto_base = 1'($urandom_range(1));
        case ($urandom_range(9))
            0: t.map_low = '0;
            1: t.map_low = '1;
            default: t.map_low = tpd_pkg::MAP_W'($urandom_range(40));
        endcase
        case ($urandom_range(9))
            0: t.map_high = '0;
            1: t.map_high = '1;
            2: t.map_high = t.map_low - tpd_pkg::MAP_W'($urandom_range(20));
            default:
            begin
                top = int'(t.map_low) + int'($urandom_range(1, 300));
                t.map_high = (top > 32767) ? '1 : tpd_pkg::MAP_W'(top);
            end
        endcase
        return t;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
        begin
            $display("%0t ns: %s", $time, what);
        end
    endtask

    task automatic write_reg(input logic [tpd_pkg::CFG_ADDR_W-1:0] index,
                             input logic [tpd_pkg::CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= index;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    task automatic apply_tuning(input tuning_t t);
        write_reg(tpd_pkg::REG_ALPHA_FREQ, tpd_pkg::CFG_DATA_W'(t.alpha_freq));
        write_reg(tpd_pkg::REG_ALPHA_DELTA, tpd_pkg::CFG_DATA_W'(t.alpha_delta));
        write_reg(tpd_pkg::REG_STABLE_EPSILON, t.epsilon);
        write_reg(tpd_pkg::REG_STABLE_TARGET, tpd_pkg::CFG_DATA_W'(t.target));
        write_reg(tpd_pkg::REG_AUTO_BASE_ENABLE, tpd_pkg::CFG_DATA_W'(t.auto_base));
        write_reg(tpd_pkg::REG_DELTA_GATE, t.gate);
        write_reg(tpd_pkg::REG_MAP_LOW, tpd_pkg::CFG_DATA_W'(t.map_low));
        write_reg(tpd_pkg::REG_MAP_HIGH, tpd_pkg::CFG_DATA_W'(t.map_high));
        cfg_we <= 1'b0;
        tuning = t;
    endtask

    task automatic wait_drained();
        while (pitch_results_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic retune(input tuning_t t);
        wait_drained();
        apply_tuning(t);
    endtask

    task automatic send_count(input logic [tpd_pkg::COUNT_W-1:0] count,
                              input logic capture);
        int gap;
        gap = 0;
        while ($urandom_range(99) < in_idle_pct)
        begin
            gap++;
        end
        if (in_idle_pct != 0 && $urandom_range(99) < 5)
        begin
            gap += $urandom_range(1, 40);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pulse_count <= count;
        capture_base <= capture;
        do
            @(posedge clk);
        while (!in_ready);
        pitch_results_due.push_back(predict_window(count, capture));
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
    endtask

    task automatic play_gestures(input int items);
        int centre;
        int count;
        int jitter;
        int roll;
        centre = $urandom_range(32767);
        jitter = $urandom_range(3);
        for (int i = 0; i < items; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 4)
            begin
                case ($urandom_range(3))
                    0: centre = 0;
                    1: centre = 32767;
                    default: centre = $urandom_range(32767);
                endcase
            end
            else if (roll < 12)
            begin
                centre = centre + int'($urandom_range(600)) - 300;
            end
            if (centre < 0)
            begin
                centre = 0;
            end
            if (centre > 32767 - jitter)
            begin
                centre = 32767 - jitter;
            end
            if (roll >= 12 && roll < 18)
            begin
                count = $urandom_range(32767);
            end
            else
            begin
                count = centre + int'($urandom_range(jitter));
            end
            send_count(tpd_pkg::COUNT_W'(count), $urandom_range(99) < 3);
        end
        end_burst();
    endtask

    task automatic test_reset_values();
        send_count('0, 1'b0);
        send_count('1, 1'b1);
        send_count('1, 1'b0);
        send_count('0, 1'b0);
        send_count(tpd_pkg::COUNT_W'(100), 1'b0);
        send_count('1, 1'b1);
        end_burst();
    endtask

    task automatic test_weight_extremes();
        tuning_t t;
        t.alpha_freq = '1;
        t.alpha_delta = tpd_pkg::WEIGHT_W'(300);
        t.epsilon = '1;
        t.target = '0;
        t.auto_base = 1'b1;
        t.gate = '1;
        t.map_low = '0;
        t.map_high = tpd_pkg::MAP_W'(1);
        retune(t);
        send_count(tpd_pkg::COUNT_W'(1234), 1'b0);
        send_count(tpd_pkg::COUNT_W'(1234), 1'b0);
        send_count(tpd_pkg::COUNT_W'(1234), 1'b1);
        send_count(tpd_pkg::COUNT_W'(20000), 1'b0);
        end_burst();
        t.alpha_freq = '0;
        t.alpha_delta = '0;
        t.epsilon = '0;
        t.target = tpd_pkg::RUN_MAX;
        t.auto_base = 1'b0;
        t.gate = '0;
        retune(t);
        send_count(tpd_pkg::COUNT_W'(5000), 1'b1);
        send_count('1, 1'b0);
        send_count('0, 1'b0);
        end_burst();
    endtask

    task automatic test_map_range();
        tuning_t                   t;
        logic [tpd_pkg::MAP_W-1:0] lows[3] = '{tpd_pkg::MAP_W'(10), tpd_pkg::MAP_W'(300),
                                               tpd_pkg::MAP_W'(0)};
        logic [tpd_pkg::MAP_W-1:0] highs[3] = '{tpd_pkg::MAP_W'(10), tpd_pkg::MAP_W'(20),
                                                '1};
        t.alpha_freq = tpd_pkg::WEIGHT_W'(tpd_pkg::WEIGHT_FULL);
        t.alpha_delta = tpd_pkg::WEIGHT_W'(tpd_pkg::WEIGHT_FULL);
        t.epsilon = '0;
        t.target = tpd_pkg::RUN_W'(1);
        t.auto_base = 1'b0;
        t.gate = '0;
        for (int i = 0; i < 3; i++)
        begin
            t.map_low = lows[i];
            t.map_high = highs[i];
            retune(t);
            send_count('1, 1'b1);
            send_count('0, 1'b0);
            send_count(tpd_pkg::COUNT_W'(9000), 1'b0);
            end_burst();
        end
    endtask

    // A long steady run with a loose epsilon and gate drives the run counter
    // into saturation, after which every step reports stable.
    task automatic test_run_saturation();
        tuning_t t;
        int      centre;
        t = reset_tuning();
        t.alpha_freq = tpd_pkg::WEIGHT_W'(tpd_pkg::WEIGHT_FULL);
        t.alpha_delta = tpd_pkg::WEIGHT_W'(tpd_pkg::WEIGHT_FULL);
        t.epsilon = '1;
        t.gate = '1;
        t.target = tpd_pkg::RUN_MAX;
        retune(t);
        centre = $urandom_range(32567);
        send_count(tpd_pkg::COUNT_W'(centre), 1'b1);
        for (int i = 0; i < 299; i++)
        begin
            send_count(tpd_pkg::COUNT_W'(centre + int'($urandom_range(200))), 1'b0);
        end
        end_burst();
    endtask

    task automatic test_backpressure();
        retune(random_tuning());
        stall_request = HOLD_OFF_CYCLES;
        play_gestures(40);
    endtask

    task automatic test_no_idle();
        retune(random_tuning());
        in_idle_pct = 0;
        out_idle_pct = 0;
        play_gestures(150);
        in_idle_pct = 17;
        out_idle_pct = 17;
    endtask

    task automatic test_random_gestures();
        for (int phase = 0; phase < 6; phase++)
        begin
            retune(random_tuning());
            play_gestures(190);
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_request != 0)
        begin
            stall_left = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_result
        pitch_result_t want;
        if (out_valid && out_ready)
        begin
            if (pitch_results_due.size() == 0)
            begin
                report_mismatch($sformatf("result transfer with none outstanding: duty %0d",
                                          duty));
            end
            else
            begin
                want = pitch_results_due.pop_front();
                if (duty !== want.duty)
                begin
                    report_mismatch($sformatf("duty: got %0d, expected %0d",
                                              duty, want.duty));
                end
                if (is_stable !== want.stable)
                begin
                    report_mismatch($sformatf("is_stable: got %0b, expected %0b",
                                              is_stable, want.stable));
                end
                if (filtered_freq !== want.freq)
                begin
                    report_mismatch($sformatf("filtered_freq: got %0d, expected %0d",
                                              filtered_freq, want.freq));
                end
                if (baseline_freq !== want.base)
                begin
                    report_mismatch($sformatf("baseline_freq: got %0d, expected %0d",
                                              baseline_freq, want.base));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (rst_n)
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", quiet_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        tuning = reset_tuning();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_values();
        test_weight_extremes();
        test_map_range();
        test_run_saturation();
        test_backpressure();
        test_no_idle();
        test_random_gestures();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
